// ===== rtl/core/ax25fc_pkg.sv =====
// ----------------------------------------------------------------------------
// ax25fc_pkg
// Shared types, constants and helper functions of the AX.25 frame chunker:
// job and configuration structs, chunk codes, CRC and address encoding.
// ----------------------------------------------------------------------------
package ax25fc_pkg;

    // segment size default and job queue depth
    localparam int SEGMENT_BYTES_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;
    localparam int JOB_IDX_W         = 8;

    // configuration register indexes
    localparam logic [2:0] REG_DEST_STATION = 3'd0;
    localparam logic [2:0] REG_SRC_STATION  = 3'd1;
    localparam logic [2:0] REG_CONTROL_PID  = 3'd2;
    localparam logic [2:0] REG_FLAG_PATTERN = 3'd3;
    localparam logic [2:0] REG_PREAMBLE_LEN = 3'd4;
    localparam logic [2:0] REG_TAIL_LEN     = 3'd5;
    localparam logic [2:0] REG_FLAG_PARAM   = 3'd6;

    // result kinds
    localparam logic [1:0] KIND_FIFO    = 2'd0;
    localparam logic [1:0] KIND_CLR_FLG = 2'd1;
    localparam logic [1:0] KIND_PA_ON   = 2'd2;
    localparam logic [1:0] KIND_PA_OFF  = 2'd3;

    // chunk bytes
    localparam logic [7:0] CHUNK_FLAG      = 8'h62;
    localparam logic [7:0] CHUNK_DATA      = 8'hE1;
    localparam logic [7:0] HDR_LEN_BYTE    = 8'd17;
    localparam logic [7:0] CRC_LEN_BYTE    = 8'h03;
    localparam logic [7:0] CRC_ARG_BYTE    = 8'h02;
    localparam logic [7:0] ZERO_BYTE       = 8'h00;
    localparam logic [7:0] FLAG_PARAM_BASE = 8'h08;
    localparam logic [7:0] SSID_BASE       = 8'h60;
    localparam logic [7:0] SPACE_CHAR      = 8'h20;
    localparam logic [7:0] CASE_OFFSET     = 8'h20;

    // crc constants
    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // register reset values
    localparam logic [15:0] CONTROL_PID_RST  = 16'h03F0;
    localparam logic [7:0]  FLAG_PATTERN_RST = 8'h7E;
    localparam logic [7:0]  PREAMBLE_LEN_RST = 8'd16;
    localparam logic [7:0]  TAIL_LEN_RST     = 8'd3;
    localparam logic [1:0]  FLAG_PARAM_RST   = 2'd1;

    typedef struct packed {
        logic [51:0] dest_station;
        logic [51:0] src_station;
        logic [15:0] control_pid;
        logic [7:0]  flag_pattern;
        logic [7:0]  preamble_len;
        logic [7:0]  tail_len;
        logic [1:0]  flag_param;
    } cfg_t;

    // one classified message byte
    typedef struct packed {
        logic [7:0]           data;
        logic                 first;
        logic                 last;
        logic                 full;
        logic [JOB_IDX_W-1:0] wr_idx;
    } job_t;

    // reflected crc-ccitt over one byte, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  din);
        logic [15:0] f;
        logic [7:0]  c;
        f = crc_in;
        c = din;
        for (int k = 0; k < 8; k++)
        begin
            if (f[0] ^ c[0])
                f = (f >> 1) ^ CRC_POLY;
            else
                f = f >> 1;
            c = c >> 1;
        end
        return f;
    endfunction

    // callsign character: zero means space, lower case folded, shifted left
    function automatic logic [7:0] addr_char(input logic [7:0] ch);
        logic [7:0] c;
        c = ch;
        if (c == ZERO_BYTE)
            c = SPACE_CHAR;
        if (c inside {[8'h61:8'h7A]})
            c = c - CASE_OFFSET;
        return {c[6:0], 1'b0};
    endfunction

    function automatic logic [7:0] ssid_byte(input logic [3:0] ssid, input logic fin);
        return SSID_BASE | {3'b000, ssid, fin};
    endfunction

    // header byte by position: two address fields, control, pid
    function automatic logic [7:0] hdr_byte(input cfg_t cfg, input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = addr_char(cfg.dest_station[51:44]);
            4'd1:    b = addr_char(cfg.dest_station[43:36]);
            4'd2:    b = addr_char(cfg.dest_station[35:28]);
            4'd3:    b = addr_char(cfg.dest_station[27:20]);
            4'd4:    b = addr_char(cfg.dest_station[19:12]);
            4'd5:    b = addr_char(cfg.dest_station[11:4]);
            4'd6:    b = ssid_byte(cfg.dest_station[3:0], 1'b0);
            4'd7:    b = addr_char(cfg.src_station[51:44]);
            4'd8:    b = addr_char(cfg.src_station[43:36]);
            4'd9:    b = addr_char(cfg.src_station[35:28]);
            4'd10:   b = addr_char(cfg.src_station[27:20]);
            4'd11:   b = addr_char(cfg.src_station[19:12]);
            4'd12:   b = addr_char(cfg.src_station[11:4]);
            4'd13:   b = ssid_byte(cfg.src_station[3:0], 1'b1);
            4'd14:   b = cfg.control_pid[15:8];
            default: b = cfg.control_pid[7:0];
        endcase
        return b;
    endfunction

    // flag count byte: count minus one, zero taken as one
    function automatic logic [7:0] flag_count(input logic [7:0] len);
        return (len == ZERO_BYTE) ? ZERO_BYTE : len - 8'd1;
    endfunction

    function automatic logic [7:0] flag_param_byte(input logic [1:0] fp);
        return FLAG_PARAM_BASE | {2'b00, fp, 4'b0000};
    endfunction

endpackage

// ===== rtl/core/ax25fc_front.sv =====
// ----------------------------------------------------------------------------
// ax25fc_front
// Input side: accepts message bytes, tracks frame and segment fill, and
// classifies each byte into a job for the sequencer.
// ----------------------------------------------------------------------------
module ax25fc_front
    import ax25fc_pkg::*;
#(
    parameter int SEGMENT_BYTES = SEGMENT_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       push_valid,
    input  logic       push_ready,
    output job_t       push_job
);

    localparam int FILL_W = (SEGMENT_BYTES > 1) ? $clog2(SEGMENT_BYTES) : 1;

    logic              in_frame_reg, in_frame_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              beat;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign beat       = in_valid && push_ready;

    // classify the byte
    always_comb
    begin
        push_job.data   = data_byte;
        push_job.first  = !in_frame_reg;
        push_job.last   = last_byte;
        push_job.wr_idx = JOB_IDX_W'(fill_reg);
        push_job.full   = (push_job.wr_idx == JOB_IDX_W'(SEGMENT_BYTES - 1));
    end

    // frame and fill tracking
    always_comb
    begin
        in_frame_next = in_frame_reg;
        fill_next     = fill_reg;
        if (beat)
        begin
            in_frame_next = !last_byte;
            if (push_job.full || last_byte)
                fill_next = '0;
            else
                fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            fill_reg     <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            fill_reg     <= fill_next;
        end
    end

    a_idle_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> fill_reg == '0)
        else $error("fill count not cleared between frames");

endmodule

// ===== rtl/core/ax25fc_queue.sv =====
// ----------------------------------------------------------------------------
// ax25fc_queue
// Short job queue between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module ax25fc_queue
    import ax25fc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg < CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = q_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= push_job;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("job queue overflow");

endmodule

// ===== rtl/core/ax25fc_back.sv =====
// ----------------------------------------------------------------------------
// ax25fc_back
// Sequencer: runs one job at a time, emits the command, preamble, header,
// segment, crc and tail chunks, keeps the crc and the segment buffer,
// drives the result register.
// ----------------------------------------------------------------------------
module ax25fc_back
    import ax25fc_pkg::*;
#(
    parameter int SEGMENT_BYTES = SEGMENT_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       job_valid,
    output logic       job_ready,
    input  job_t       job,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_kind,
    output logic [7:0] out_byte,
    output logic       commit_after,
    output logic       last_of_run
);

    localparam int IDX_W = (SEGMENT_BYTES > 1) ? $clog2(SEGMENT_BYTES) : 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_PRE      = 3'd1;
    localparam logic [2:0] ST_HDR      = 3'd2;
    localparam logic [2:0] ST_DATA     = 3'd3;
    localparam logic [2:0] ST_SEG_HDR  = 3'd4;
    localparam logic [2:0] ST_SEG_BYTE = 3'd5;
    localparam logic [2:0] ST_TAIL     = 3'd6;

    // last step of each counted state
    localparam logic [3:0] PRE_LAST     = 4'd8;
    localparam logic [3:0] HDR_LAST     = 4'd15;
    localparam logic [3:0] SEG_HDR_LAST = 4'd2;
    localparam logic [3:0] TAIL_LAST    = 4'd9;

    logic [2:0]           state_reg, state_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic [JOB_IDX_W-1:0] seg_idx_reg, seg_idx_next;
    logic [15:0]          crc_reg, crc_next;
    job_t                 job_reg, job_next;

    logic [7:0]           seg_mem [SEGMENT_BYTES];
    logic [7:0]           rd_data_reg;
    logic                 mem_we;

    logic                 out_valid_reg;
    logic [1:0]           out_kind_reg;
    logic [7:0]           out_byte_reg;
    logic                 commit_after_reg;
    logic                 last_of_run_reg;

    logic                 adv;
    logic                 item_emit;
    logic [1:0]           item_kind;
    logic [7:0]           item_byte;
    logic                 item_commit;
    logic                 item_last;
    logic                 seg_final;
    logic [15:0]          fcs;
    logic [7:0]           crc_din;
    logic [15:0]          crc_upd;

    assign adv       = !out_valid_reg || out_ready;
    assign job_ready = (state_reg == ST_IDLE);
    assign seg_final = (seg_idx_reg == job_reg.wr_idx);
    assign fcs       = ~crc_reg;
    assign crc_din   = (state_reg == ST_HDR) ? item_byte : job_reg.data;
    assign crc_upd   = crc_byte(crc_reg, crc_din);

    // item generation and sequencing
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        seg_idx_next = seg_idx_reg;
        crc_next     = crc_reg;
        job_next     = job_reg;
        mem_we       = 1'b0;
        item_emit    = 1'b0;
        item_kind    = KIND_FIFO;
        item_byte    = ZERO_BYTE;
        item_commit  = 1'b0;
        item_last    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_next = job;
                    if (job.first)
                    begin
                        state_next = ST_PRE;
                        cnt_next   = '0;
                        crc_next   = CRC_INIT;
                    end
                    else
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_PRE:
            begin
                item_emit = 1'b1;
                case (cnt_reg)
                    4'd0:    item_kind = KIND_CLR_FLG;
                    4'd1:    item_kind = KIND_PA_ON;
                    4'd2:    item_byte = CHUNK_FLAG;
                    4'd3:    item_byte = flag_param_byte(cfg.flag_param);
                    4'd4:    item_byte = flag_count(cfg.preamble_len);
                    4'd5:
                    begin
                        item_byte   = cfg.flag_pattern;
                        item_commit = 1'b1;
                    end
                    4'd6:    item_byte = CHUNK_DATA;
                    4'd7:    item_byte = HDR_LEN_BYTE;
                    default: item_byte = ZERO_BYTE;
                endcase
                if (adv)
                begin
                    if (cnt_reg == PRE_LAST)
                    begin
                        state_next = ST_HDR;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_HDR:
            begin
                item_emit   = 1'b1;
                item_byte   = hdr_byte(cfg, cnt_reg);
                item_commit = (cnt_reg == HDR_LAST);
                item_last   = (cnt_reg == HDR_LAST) && !job_reg.full && !job_reg.last;
                if (adv)
                begin
                    crc_next = crc_upd;
                    if (cnt_reg == HDR_LAST)
                        state_next = ST_DATA;
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DATA:
            begin
                mem_we   = 1'b1;
                crc_next = crc_upd;
                if (job_reg.full || job_reg.last)
                begin
                    state_next   = ST_SEG_HDR;
                    cnt_next     = '0;
                    seg_idx_next = '0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEG_HDR:
            begin
                item_emit = 1'b1;
                case (cnt_reg)
                    4'd0:    item_byte = CHUNK_DATA;
                    4'd1:    item_byte = 8'(job_reg.wr_idx + 8'd2);
                    default: item_byte = ZERO_BYTE;
                endcase
                if (adv)
                begin
                    if (cnt_reg == SEG_HDR_LAST)
                        state_next = ST_SEG_BYTE;
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SEG_BYTE:
            begin
                item_emit   = 1'b1;
                item_byte   = rd_data_reg;
                item_commit = seg_final;
                item_last   = seg_final && !job_reg.last;
                if (adv)
                begin
                    if (seg_final)
                    begin
                        state_next = job_reg.last ? ST_TAIL : ST_IDLE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        seg_idx_next = seg_idx_reg + 1'b1;
                    end
                end
            end
            ST_TAIL:
            begin
                item_emit = 1'b1;
                case (cnt_reg)
                    4'd0:    item_byte = CHUNK_DATA;
                    4'd1:    item_byte = CRC_LEN_BYTE;
                    4'd2:    item_byte = CRC_ARG_BYTE;
                    4'd3:    item_byte = fcs[7:0];
                    4'd4:
                    begin
                        item_byte   = fcs[15:8];
                        item_commit = 1'b1;
                    end
                    4'd5:    item_byte = CHUNK_FLAG;
                    4'd6:    item_byte = flag_param_byte(cfg.flag_param);
                    4'd7:    item_byte = flag_count(cfg.tail_len);
                    4'd8:
                    begin
                        item_byte   = cfg.flag_pattern;
                        item_commit = 1'b1;
                    end
                    default:
                    begin
                        item_kind = KIND_PA_OFF;
                        item_last = 1'b1;
                    end
                endcase
                if (adv)
                begin
                    if (cnt_reg == TAIL_LAST)
                        state_next = ST_IDLE;
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            seg_idx_reg <= '0;
            crc_reg     <= CRC_INIT;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            seg_idx_reg <= seg_idx_next;
            crc_reg     <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    // segment buffer, registered read one step ahead
    always_ff @(posedge clk)
    begin
        if (mem_we)
            seg_mem[job_reg.wr_idx[IDX_W-1:0]] <= job_reg.data;
        rd_data_reg <= seg_mem[seg_idx_next[IDX_W-1:0]];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (item_emit && adv)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_emit && adv)
        begin
            out_kind_reg     <= item_kind;
            out_byte_reg     <= item_byte;
            commit_after_reg <= item_commit;
            last_of_run_reg  <= item_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_byte     = out_byte_reg;
    assign commit_after = commit_after_reg;
    assign last_of_run  = last_of_run_reg;

    a_first_starts_preamble: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && job_valid && job.first |=> state_reg == ST_PRE)
        else $error("first byte did not start the preamble");

    a_seg_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEG_BYTE) |-> seg_idx_reg <= job_reg.wr_idx)
        else $error("segment read index past fill");

    a_cmd_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_kind_reg != KIND_FIFO)
            |-> (out_byte_reg == ZERO_BYTE) && !commit_after_reg)
        else $error("command item carries a byte or commit");

endmodule

// ===== rtl/core/ax25_frame_chunker.sv =====
// ----------------------------------------------------------------------------
// ax25_frame_chunker
// Builds the radio transmit FIFO stream of one AX.25 UI frame from message
// bytes: commands, preamble, header, data segments, fcs and tail.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one message byte per beat, last_byte
//   set on the final byte of the message. Output channel (out_valid/
//   out_ready): one FIFO byte or radio command per beat.
//   Configuration: cfg_write/cfg_index/cfg_data, written while idle.
//   A classifier takes bytes into a two-entry job queue; a sequencer works
//   off one job at a time and owns the crc and the segment buffer.
//   Throughput: a plain message byte emits no item; emitted items leave at
//   one per cycle while out_ready is high. The first byte of a frame passes
//   the job queue, sequencer and result register, and yields 25 items of
//   commands, preamble and header. A byte that closes a segment adds 3 items
//   plus one per byte of the segment, read one per cycle from the segment
//   buffer while out_ready is high; the last byte adds the fcs chunk, tail
//   flag chunk and PA off, and marks its final item with last_of_run. A
//   stalled receiver holds the result register and the emitting sequencer
//   states; the input side keeps taking bytes until the job queue fills.
//   Reset: leaves the block idle between frames with default registers.
// ----------------------------------------------------------------------------
module ax25_frame_chunker
    import ax25fc_pkg::*;
#(
    parameter int SEGMENT_BYTES = SEGMENT_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [51:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic        commit_after,
    output logic        last_of_run
);

    cfg_t cfg_reg, cfg_next;
    logic push_valid, push_ready;
    job_t push_job;
    logic pop_valid, pop_ready;
    job_t pop_job;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_DEST_STATION: cfg_next.dest_station = cfg_data;
                REG_SRC_STATION:  cfg_next.src_station  = cfg_data;
                REG_CONTROL_PID:  cfg_next.control_pid  = cfg_data[15:0];
                REG_FLAG_PATTERN: cfg_next.flag_pattern = cfg_data[7:0];
                REG_PREAMBLE_LEN: cfg_next.preamble_len = cfg_data[7:0];
                REG_TAIL_LEN:     cfg_next.tail_len     = cfg_data[7:0];
                REG_FLAG_PARAM:   cfg_next.flag_param   = cfg_data[1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_station <= '0;
            cfg_reg.src_station  <= '0;
            cfg_reg.control_pid  <= CONTROL_PID_RST;
            cfg_reg.flag_pattern <= FLAG_PATTERN_RST;
            cfg_reg.preamble_len <= PREAMBLE_LEN_RST;
            cfg_reg.tail_len     <= TAIL_LEN_RST;
            cfg_reg.flag_param   <= FLAG_PARAM_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classifier
    ax25fc_front #(
        .SEGMENT_BYTES (SEGMENT_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // job queue
    ax25fc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // sequencer
    ax25fc_back #(
        .SEGMENT_BYTES (SEGMENT_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job_valid    (pop_valid),
        .job_ready    (pop_ready),
        .job          (pop_job),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_kind     (out_kind),
        .out_byte     (out_byte),
        .commit_after (commit_after),
        .last_of_run  (last_of_run)
    );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ax25_frame_chunker. Message bytes are driven over
// the input handshake and every output beat is compared with a behavioural
// frame builder kept in step: commands, flag chunks, the address header,
// data segments and the fcs chunk. A short table of directed bytes with
// spot values comes first, then random messages under random register
// settings, with random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb;
    import ax25fc_pkg::*;

    localparam int SEG_BYTES   = SEGMENT_BYTES_DEF;
    localparam int MSG_BYTES   = 450;
    localparam int SETTLE      = 12;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int REPORT_CAP  = 40;

    // register index with no register behind it
    localparam logic [2:0] REG_NONE = 3'd7;

    // one output beat as seen on the result port
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       commit;
        logic       run_end;
    } tx_item_t;

    // directed row: byte, last marker, setting to load first, spot check
    typedef struct {
        logic [7:0] d;
        logic       l;
        int         setting;
        int         spot;
        logic [1:0] kind;
        logic [7:0] value;
    } probe_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [51:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic        commit_after;
    logic        last_of_run;

    // frame builder state
    cfg_t        model_cfg;
    logic [15:0] fcs_acc;
    logic [7:0]  seg_buf [SEG_BYTES];
    int          seg_fill;
    bit          framing;

    tx_item_t    step_items[$];
    tx_item_t    tx_expected[$];

    int          errors;
    int          cycle_count;
    int          bytes_sent;
    int          frames_sent;
    int          beats_checked;
    int          setting_loads;
    int          stall_left;
    bit          calm;

    probe_row_t  plan [22];
    cfg_t        presets [3];

    ax25_frame_chunker uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_kind     (out_kind),
        .out_byte     (out_byte),
        .commit_after (commit_after),
        .last_of_run  (last_of_run)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d beats still expected",
                     $time, tx_expected.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // reflected crc-ccitt, one byte lsb first
    function automatic logic [15:0] fcs_update(input logic [15:0] acc, input logic [7:0] din);
        logic [15:0] f;
        logic [7:0]  c;
        f = acc;
        c = din;
        for (int k = 0; k < 8; k++)
        begin
            f = (f[0] ^ c[0]) ? ((f >> 1) ^ CRC_POLY) : (f >> 1);
            c = c >> 1;
        end
        return f;
    endfunction

    task automatic push_item(input logic [1:0] kind, input logic [7:0] value,
                             input logic commit);
        step_items.push_back('{kind, value, commit, 1'b0});
    endtask

    // header bytes also feed the fcs
    task automatic push_header(input logic [7:0] value, input logic commit);
        push_item(KIND_FIFO, value, commit);
        fcs_acc = fcs_update(fcs_acc, value);
    endtask

    // six callsign characters then the ssid byte
    task automatic push_station(input logic [51:0] st, input logic final_addr);
        logic [7:0] ch;
        for (int i = 0; i < 6; i++)
        begin
            ch = st[51 - 8 * i -: 8];
            if (ch == 8'h00)
                ch = 8'h20;
            if (ch >= 8'h61 && ch <= 8'h7A)
                ch = ch - 8'h20;
            push_header({ch[6:0], 1'b0}, 1'b0);
        end
        push_header(SSID_BASE | {3'b000, st[3:0], final_addr}, 1'b0);
    endtask

    // flag chunk: code, parameter, count minus one, pattern
    task automatic push_flags(input logic [7:0] count);
        push_item(KIND_FIFO, CHUNK_FLAG, 1'b0);
        push_item(KIND_FIFO, FLAG_PARAM_BASE | {2'b00, model_cfg.flag_param, 4'b0000}, 1'b0);
        push_item(KIND_FIFO, (count == 8'h00) ? 8'h00 : count - 8'd1, 1'b0);
        push_item(KIND_FIFO, model_cfg.flag_pattern, 1'b1);
    endtask

    task automatic push_segment();
        push_item(KIND_FIFO, CHUNK_DATA, 1'b0);
        push_item(KIND_FIFO, 8'(seg_fill + 1), 1'b0);
        push_item(KIND_FIFO, ZERO_BYTE, 1'b0);
        for (int i = 0; i < seg_fill; i++)
            push_item(KIND_FIFO, seg_buf[i], (i + 1 == seg_fill));
        seg_fill = 0;
    endtask

    // works out the beats caused by one message byte
    task automatic frame_model(input logic [7:0] d, input logic l);
        logic [15:0] fcs;
        tx_item_t    it;
        int          n;
        step_items.delete();
        if (!framing)
        begin
            framing  = 1'b1;
            fcs_acc  = CRC_INIT;
            seg_fill = 0;
            push_item(KIND_CLR_FLG, ZERO_BYTE, 1'b0);
            push_item(KIND_PA_ON, ZERO_BYTE, 1'b0);
            push_flags(model_cfg.preamble_len);
            push_item(KIND_FIFO, CHUNK_DATA, 1'b0);
            push_item(KIND_FIFO, HDR_LEN_BYTE, 1'b0);
            push_item(KIND_FIFO, ZERO_BYTE, 1'b0);
            push_station(model_cfg.dest_station, 1'b0);
            push_station(model_cfg.src_station, 1'b1);
            push_header(model_cfg.control_pid[15:8], 1'b0);
            push_header(model_cfg.control_pid[7:0], 1'b1);
        end
        fcs_acc = fcs_update(fcs_acc, d);
        seg_buf[seg_fill] = d;
        seg_fill++;
        if (seg_fill >= SEG_BYTES)
            push_segment();
        if (l)
        begin
            fcs = ~fcs_acc;
            if (seg_fill != 0)
                push_segment();
            push_item(KIND_FIFO, CHUNK_DATA, 1'b0);
            push_item(KIND_FIFO, CRC_LEN_BYTE, 1'b0);
            push_item(KIND_FIFO, CRC_ARG_BYTE, 1'b0);
            push_item(KIND_FIFO, fcs[7:0], 1'b0);
            push_item(KIND_FIFO, fcs[15:8], 1'b1);
            push_flags(model_cfg.tail_len);
            push_item(KIND_PA_OFF, ZERO_BYTE, 1'b0);
            fcs_acc  = CRC_INIT;
            seg_fill = 0;
            framing  = 1'b0;
            frames_sent++;
        end
        n = step_items.size();
        for (int i = 0; i < n; i++)
        begin
            it = step_items[i];
            it.run_end = (i == n - 1);
            step_items[i] = it;
            tx_expected.push_back(it);
        end
    endtask

    // random 52-bit word
    function automatic logic [51:0] junk52();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[51:0];
    endfunction

    // register write, one beat per falling edge
    task automatic write_reg(input logic [2:0] idx, input logic [51:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_DEST_STATION: model_cfg.dest_station = val;
            REG_SRC_STATION:  model_cfg.src_station  = val;
            REG_CONTROL_PID:  model_cfg.control_pid  = val[15:0];
            REG_FLAG_PATTERN: model_cfg.flag_pattern = val[7:0];
            REG_PREAMBLE_LEN: model_cfg.preamble_len = val[7:0];
            REG_TAIL_LEN:     model_cfg.tail_len     = val[7:0];
            REG_FLAG_PARAM:   model_cfg.flag_param   = val[1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // all seven registers, unused upper data bits filled with noise
    task automatic load_setting(input cfg_t s);
        logic [51:0] j;
        j = junk52();
        write_reg(REG_DEST_STATION, s.dest_station);
        write_reg(REG_SRC_STATION, s.src_station);
        write_reg(REG_CONTROL_PID, {j[51:16], s.control_pid});
        write_reg(REG_FLAG_PATTERN, {j[51:8], s.flag_pattern});
        write_reg(REG_PREAMBLE_LEN, {j[50:7], s.preamble_len});
        write_reg(REG_TAIL_LEN, {j[49:6], s.tail_len});
        write_reg(REG_FLAG_PARAM, {j[51:2], s.flag_param});
        cfg_write <= 1'b0;
        setting_loads++;
    endtask

    function automatic logic [51:0] random_station();
        logic [51:0] st;
        logic [7:0]  ch;
        for (int i = 0; i < 6; i++)
        begin
            case ($urandom_range(0, 7))
                0:       ch = 8'h00;
                1, 2:    ch = 8'($urandom_range(8'h61, 8'h7A));
                3, 4:    ch = 8'($urandom_range(8'h41, 8'h5A));
                5:       ch = 8'($urandom_range(8'h30, 8'h39));
                default: ch = 8'($urandom_range(0, 255));
            endcase
            st[51 - 8 * i -: 8] = ch;
        end
        st[3:0] = 4'($urandom_range(0, 15));
        return st;
    endfunction

    // flag counts and patterns lean towards the extremes
    function automatic logic [7:0] random_octet();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic cfg_t random_setting();
        cfg_t s;
        s.dest_station = random_station();
        s.src_station  = random_station();
        case ($urandom_range(0, 4))
            0:       s.control_pid = CONTROL_PID_RST;
            1:       s.control_pid = 16'h0000;
            2:       s.control_pid = 16'hFFFF;
            default: s.control_pid = 16'($urandom_range(0, 65535));
        endcase
        s.flag_pattern = random_octet();
        s.preamble_len = random_octet();
        s.tail_len     = random_octet();
        s.flag_param   = 2'($urandom_range(0, 3));
        return s;
    endfunction

    // sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(15, 50);
    endfunction

    // one input beat; entered and left at a falling edge
    task automatic send_beat(input logic [7:0] d, input logic l, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        last_byte <= l;
        do
            @(posedge clk);
        while (!in_ready);
        frame_model(d, l);
        bytes_sent++;
        @(negedge clk);
    endtask

    // drop valid, wait for every expected beat, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (tx_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        if (calm)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            case ($urandom_range(0, 99)) inside
                [0:69]:
                    out_ready <= 1'b1;
                [70:96]:
                begin
                    stall_left <= $urandom_range(0, 3);
                    out_ready  <= 1'b0;
                end
                default:
                begin
                    stall_left <= $urandom_range(20, 40);
                    out_ready  <= 1'b0;
                end
            endcase
        end
    end

    // output check against the oldest expected beat
    always @(posedge clk)
    begin
        tx_item_t got;
        tx_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{out_kind, out_byte, commit_after, last_of_run};
            if (tx_expected.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display({"%0t unexpected beat: expected none, ",
                              "got kind %0d byte %02h commit %0d last %0d"},
                             $time, got.kind, got.value, got.commit, got.run_end);
            end
            else
            begin
                want = tx_expected.pop_front();
                beats_checked++;
                if (got !== want)
                begin
                    errors++;
                    if (errors <= REPORT_CAP)
                        $display({"%0t mismatch: expected kind %0d byte %02h ",
                                  "commit %0d last %0d, got kind %0d byte %02h ",
                                  "commit %0d last %0d"},
                                 $time, want.kind, want.value, want.commit, want.run_end,
                                 got.kind, got.value, got.commit, got.run_end);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        tx_item_t probe;
        int       len;
        cfg_write     = 1'b0;
        cfg_index     = REG_DEST_STATION;
        cfg_data      = '0;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        last_byte     = 1'b0;
        out_ready     = 1'b0;
        rst_n         = 1'b0;
        errors        = 0;
        cycle_count   = 0;
        bytes_sent    = 0;
        frames_sent   = 0;
        beats_checked = 0;
        setting_loads = 0;
        stall_left    = 0;
        calm          = 1'b0;

        // builder starts from the register reset values
        model_cfg = '{dest_station: '0, src_station: '0, control_pid: CONTROL_PID_RST,
                      flag_pattern: FLAG_PATTERN_RST, preamble_len: PREAMBLE_LEN_RST,
                      tail_len: TAIL_LEN_RST, flag_param: FLAG_PARAM_RST};
        fcs_acc   = CRC_INIT;
        seg_fill  = 0;
        framing   = 1'b0;

        // preset settings: case folding edges with zero preamble, an all ones source
        // station with zero tail, a lower case destination with the longest preamble
        presets[0] = '{dest_station: 52'h617A607B00FF_F, src_station: 52'h415A207F8001_0,
                       control_pid: 16'hFFFF, flag_pattern: 8'hFF, preamble_len: 8'd0,
                       tail_len: 8'd255, flag_param: 2'd3};
        presets[1] = '{dest_station: 52'h0, src_station: 52'hF_FFFF_FFFF_FFFF,
                       control_pid: 16'h0000, flag_pattern: 8'h00, preamble_len: 8'd1,
                       tail_len: 8'd0, flag_param: 2'd0};
        presets[2] = '{dest_station: 52'h6E3063616C6C_7, src_station: 52'h544553543031_A,
                       control_pid: CONTROL_PID_RST, flag_pattern: 8'h7E,
                       preamble_len: 8'd255, tail_len: 8'd1, flag_param: 2'd2};

        // single byte after reset, a message that exactly fills one segment,
        // then short messages under each preset
        plan = '{
            '{8'h00, 1'b1, -1,  0, KIND_CLR_FLG, 8'h00},
            '{8'hFF, 1'b0, -1,  4, KIND_FIFO,    8'h0F},
            '{8'h01, 1'b0, -1, -1, KIND_FIFO,    8'h00},
            '{8'h02, 1'b0, -1, -1, KIND_FIFO,    8'h00},
            '{8'h04, 1'b0, -1, -1, KIND_FIFO,    8'h00},
            '{8'h08, 1'b0, -1, -1, KIND_FIFO,    8'h00},
            '{8'h10, 1'b0, -1, -1, KIND_FIFO,    8'h00},
            '{8'h20, 1'b0, -1, -1, KIND_FIFO,    8'h00},
            '{8'h40, 1'b0, -1, -1, KIND_FIFO,    8'h00},
            '{8'h80, 1'b0, -1, -1, KIND_FIFO,    8'h00},
            '{8'hFE, 1'b0, -1, -1, KIND_FIFO,    8'h00},
            '{8'hFD, 1'b0, -1, -1, KIND_FIFO,    8'h00},
            '{8'hFB, 1'b0, -1, -1, KIND_FIFO,    8'h00},
            '{8'hF7, 1'b0, -1, -1, KIND_FIFO,    8'h00},
            '{8'hEF, 1'b0, -1, -1, KIND_FIFO,    8'h00},
            '{8'hDF, 1'b0, -1, -1, KIND_FIFO,    8'h00},
            '{8'hBF, 1'b1, -1,  1, KIND_FIFO,    8'h11},
            '{8'h80, 1'b0,  0,  9, KIND_FIFO,    8'h82},
            '{8'h7F, 1'b1, -1, 12, KIND_FIFO,    8'hFE},
            '{8'h55, 1'b1,  1,  4, KIND_FIFO,    8'h00},
            '{8'hAA, 1'b0,  2,  3, KIND_FIFO,    8'h28},
            '{8'h5A, 1'b1, -1, 12, KIND_FIFO,    8'h00}
        };

        // reset
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        foreach (plan[r])
        begin
            if (plan[r].setting >= 0)
            begin
                drain();
                load_setting(presets[plan[r].setting]);
            end
            send_beat(plan[r].d, plan[r].l, pick_gap());
            if (plan[r].spot >= 0)
            begin
                probe = step_items[plan[r].spot];
                if (probe.kind !== plan[r].kind || probe.value !== plan[r].value)
                begin
                    errors++;
                    $display({"%0t spot value: expected kind %0d byte %02h, ",
                              "got kind %0d byte %02h"},
                             $time, plan[r].kind, plan[r].value, probe.kind, probe.value);
                end
            end
        end

        // the unused register index must leave every setting alone
        drain();
        write_reg(REG_NONE, junk52());
        cfg_write <= 1'b0;
        @(negedge clk);

        // random messages, settings changed between some of them
        while (bytes_sent < MSG_BYTES)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                drain();
                load_setting(random_setting());
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(1, 20);
                6, 7, 8:          len = $urandom_range(21, 48);
                default:          len = $urandom_range(49, 80);
            endcase
            calm = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < len; k++)
                send_beat(8'($urandom_range(0, 255)), (k == len - 1), pick_gap());
        end
        calm = 1'b0;
        drain();

        $display("covered %0d frames from %0d message bytes, %0d beats checked",
                 frames_sent, bytes_sent, beats_checked);
        $display("register settings loaded %0d times, %0d failures", setting_loads, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== ax25_frame_chunker.f =====
rtl/core/ax25fc_pkg.sv
rtl/core/ax25fc_front.sv
rtl/core/ax25fc_queue.sv
rtl/core/ax25fc_back.sv
rtl/core/ax25_frame_chunker.sv
tb/sv/tb.sv
